@@ hw/rtl/dsil_pkg.sv @@
package dsil_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int DEPTH_BITS  = 16;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = HANDLE_BITS + DEPTH_BITS;
  localparam int SLOT_W  = 6;
  localparam int CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic hit;
    logic gt;
  } cmp_res_t;

endpackage

@@ hw/rtl/depth_sorted_insert_list.sv @@
// Keeps up to CAPACITY (handle, depth) entries sorted by ascending signed depth in a RAM with
// one read and one write port, and answers every input transfer with exactly one result
// transfer. A place item walks the whole list once, one entry per cycle through one shared
// handle and depth comparator, to find the old copy of the handle and the insert point. It then
// moves the entries between the old copy (or the end of the list) and the insert point one per
// cycle and writes the new entry; a new handle into a full list is dropped with status FULL. The
// single read port of the RAM sets this pace. in_tready is high only while the block is idle; a
// finished result waits in the output register while the next item is accepted.
module depth_sorted_insert_list
  import dsil_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // handle[15:0], depth[31:16], slot[37:32], zero pad
  input  logic        in_tuser,  // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // position[5:0], count[12:6], out_handle[28:13],
                                 // out_depth[44:29], zero pad
  output logic [1:0]  out_tuser  // status[1:0]
);

  logic [HANDLE_BITS-1:0] key_h;
  logic [DEPTH_BITS-1:0]  key_d;
  cmp_res_t               cmp_res;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  status_t                out_status;
  logic [5:0]             out_pos;
  logic [6:0]             out_cnt;
  logic [15:0]            out_h;
  logic [15:0]            out_d;

  dsil_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_h       (HANDLE_BITS'(in_tdata[15:0])),
    .in_d       (DEPTH_BITS'(in_tdata[31:16])),
    .in_slot    (in_tdata[37:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_pos    (out_pos),
    .out_cnt    (out_cnt),
    .out_h      (out_h),
    .out_d      (out_d),
    .key_h      (key_h),
    .key_d      (key_d),
    .cmp_res    (cmp_res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  dsil_cmp u_cmp (
    .entry_h (ram_rdata[ENTRY_W-1:DEPTH_BITS]),
    .entry_d (ram_rdata[DEPTH_BITS-1:0]),
    .key_h   (key_h),
    .key_d   (key_d),
    .res     (cmp_res)
  );

  dsil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {3'b000, out_d, out_h, out_cnt, out_pos};
  assign out_tuser = out_status;

endmodule

@@ hw/rtl/dsil_ram.sv @@
module dsil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dsil_cmp.sv @@
module dsil_cmp
  import dsil_pkg::*;
(
  input  logic [HANDLE_BITS-1:0] entry_h,
  input  logic [DEPTH_BITS-1:0]  entry_d,
  input  logic [HANDLE_BITS-1:0] key_h,
  input  logic [DEPTH_BITS-1:0]  key_d,
  output cmp_res_t               res
);

  assign res.hit = (entry_h == key_h);
  assign res.gt  = ($signed(entry_d) > $signed(key_d));

endmodule

@@ hw/rtl/dsil_seq.sv @@
module dsil_seq
  import dsil_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_kind,
  input  logic [HANDLE_BITS-1:0] in_h,
  input  logic [DEPTH_BITS-1:0]  in_d,
  input  logic [SLOT_W-1:0]      in_slot,
  output logic                   out_valid,
  input  logic                   out_ready,
  output status_t                out_status,
  output logic [5:0]             out_pos,
  output logic [6:0]             out_cnt,
  output logic [15:0]            out_h,
  output logic [15:0]            out_d,
  output logic [HANDLE_BITS-1:0] key_h,
  output logic [DEPTH_BITS-1:0]  key_d,
  input  cmp_res_t               cmp_res,
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [ENTRY_W-1:0]     ram_wdata,
  output logic [IDX_W-1:0]       ram_raddr,
  input  logic [ENTRY_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDW,
    S_SCAN,
    S_MOVE,
    S_PUT,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [HANDLE_BITS-1:0] key_h_r, key_h_nxt;
  logic [DEPTH_BITS-1:0]  key_d_r, key_d_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [CNT_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                   dv_r, dv_nxt;
  logic [CNT_W-1:0]       di_r, di_nxt;
  logic                   found_r, found_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic                   posf_r, posf_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]       nc_r, nc_nxt;
  logic                   up_r, up_nxt;
  logic [CNT_W-1:0]       src_r, src_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  logic                   pv_r, pv_nxt;
  logic [CNT_W-1:0]       pdst_r, pdst_nxt;
  status_t                res_st_r, res_st_nxt;
  logic [CNT_W-1:0]       res_pos_r, res_pos_nxt;
  logic [CNT_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic [HANDLE_BITS-1:0] res_h_r, res_h_nxt;
  logic [DEPTH_BITS-1:0]  res_d_r, res_d_nxt;
  logic                   ov_r, ov_nxt;
  status_t                ost_r, ost_nxt;
  logic [5:0]             opos_r, opos_nxt;
  logic [6:0]             ocnt_r, ocnt_nxt;
  logic [15:0]            oh_r, oh_nxt;
  logic [15:0]            od_r, od_nxt;

  logic                   issue;
  logic [CNT_W-1:0]       nc;
  logic [CNT_W-1:0]       p;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_pos    = opos_r;
  assign out_cnt    = ocnt_r;
  assign out_h      = oh_r;
  assign out_d      = od_r;
  assign key_h      = key_h_r;
  assign key_d      = key_d_r;

  assign issue = (rd_ptr_r < cnt_r);
  assign nc    = cnt_r - CNT_W'(found_r);
  assign p     = posf_r ? pos_r : nc;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    key_h_nxt   = key_h_r;
    key_d_nxt   = key_d_r;
    slot_nxt    = slot_r;
    rd_ptr_nxt  = rd_ptr_r;
    dv_nxt      = 1'b0;
    di_nxt      = di_r;
    found_nxt   = found_r;
    rem_nxt     = rem_r;
    posf_nxt    = posf_r;
    pos_nxt     = pos_r;
    nc_nxt      = nc_r;
    up_nxt      = up_r;
    src_nxt     = src_r;
    left_nxt    = left_r;
    pv_nxt      = 1'b0;
    pdst_nxt    = pdst_r;
    res_st_nxt  = res_st_r;
    res_pos_nxt = res_pos_r;
    res_cnt_nxt = res_cnt_r;
    res_h_nxt   = res_h_r;
    res_d_nxt   = res_d_r;
    ov_nxt      = ov_r & ~out_ready;
    ost_nxt     = ost_r;
    opos_nxt    = opos_r;
    ocnt_nxt    = ocnt_r;
    oh_nxt      = oh_r;
    od_nxt      = od_r;
    ram_we      = 1'b0;
    ram_waddr   = pdst_r[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = rd_ptr_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_h_nxt = in_h;
          key_d_nxt = in_d;
          slot_nxt  = in_slot;
          if (in_kind == KIND_READ) begin
            ram_raddr = IDX_W'(in_slot);
            state_nxt = S_RDW;
          end else begin
            rd_ptr_nxt = '0;
            found_nxt  = 1'b0;
            posf_nxt   = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_RDW: begin
        res_pos_nxt = CNT_W'(slot_r);
        res_cnt_nxt = cnt_r;
        if (CMP_W'(slot_r) < CMP_W'(cnt_r)) begin
          res_st_nxt = ST_OK;
          res_h_nxt  = ram_rdata[ENTRY_W-1:DEPTH_BITS];
          res_d_nxt  = ram_rdata[DEPTH_BITS-1:0];
        end else begin
          res_st_nxt = ST_EMPTY;
          res_h_nxt  = '0;
          res_d_nxt  = '0;
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        dv_nxt = issue;
        di_nxt = rd_ptr_r;
        if (issue) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        if (dv_r) begin
          if (!found_r && cmp_res.hit) begin
            found_nxt = 1'b1;
            rem_nxt   = di_r;
          end else if (!posf_r && cmp_res.gt) begin
            posf_nxt = 1'b1;
            pos_nxt  = found_r ? di_r - 1'b1 : di_r;
          end
        end
        if (!issue && !dv_r) begin
          res_h_nxt = '0;
          res_d_nxt = '0;
          if (!found_r && cnt_r == CNT_W'(CAPACITY)) begin
            res_st_nxt  = ST_FULL;
            res_pos_nxt = '0;
            res_cnt_nxt = cnt_r;
            state_nxt   = S_EMIT;
          end else begin
            nc_nxt  = nc;
            pos_nxt = p;
            if (!found_r || p < rem_r) begin
              up_nxt   = 1'b1;
              src_nxt  = found_r ? rem_r - 1'b1 : cnt_r - 1'b1;
              left_nxt = (found_r ? rem_r : cnt_r) - p;
            end else begin
              up_nxt   = 1'b0;
              src_nxt  = rem_r + 1'b1;
              left_nxt = p - rem_r;
            end
            state_nxt = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        ram_raddr = src_r[IDX_W-1:0];
        pv_nxt    = (left_r != '0);
        pdst_nxt  = up_r ? src_r + 1'b1 : src_r - 1'b1;
        if (left_r != '0) begin
          src_nxt  = up_r ? src_r - 1'b1 : src_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end
        if (pv_r) begin
          ram_we = 1'b1;
        end
        if (left_r == '0 && !pv_r) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_r[IDX_W-1:0];
        ram_wdata   = {key_h_r, key_d_r};
        cnt_nxt     = nc_r + 1'b1;
        res_st_nxt  = ST_OK;
        res_pos_nxt = pos_r;
        res_cnt_nxt = nc_r + 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          opos_nxt  = 6'(res_pos_r);
          ocnt_nxt  = 7'(res_cnt_r);
          oh_nxt    = 16'(res_h_r);
          od_nxt    = 16'(res_d_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
      posf_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
      posf_r  <= posf_nxt;
      ov_r    <= ov_nxt;
    end
    key_h_r   <= key_h_nxt;
    key_d_r   <= key_d_nxt;
    slot_r    <= slot_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    di_r      <= di_nxt;
    rem_r     <= rem_nxt;
    pos_r     <= pos_nxt;
    nc_r      <= nc_nxt;
    up_r      <= up_nxt;
    src_r     <= src_nxt;
    left_r    <= left_nxt;
    pdst_r    <= pdst_nxt;
    res_st_r  <= res_st_nxt;
    res_pos_r <= res_pos_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_h_r   <= res_h_nxt;
    res_d_r   <= res_d_nxt;
    ost_r     <= ost_nxt;
    opos_r    <= opos_nxt;
    ocnt_r    <= ocnt_nxt;
    oh_r      <= oh_nxt;
    od_r      <= od_nxt;
  end

endmodule

@@ hw/rtl/dsil_chk.sv @@
module dsil_chk
  import dsil_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken while an item is in work.");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |->
      out_tdata[5:0] == 6'd0 && out_tdata[12:6] == 7'(CAPACITY) && out_tdata[44:13] == '0)
    else $error("Dropped place result is malformed.");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[44:13] == '0)
    else $error("Empty slot read returned data.");

endmodule

bind depth_sorted_insert_list dsil_chk u_chk (.*);
